// ----- src/frame_window_multiplier_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the frame window multiplier
// Shared concurrent-assertion wrappers, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FRAME_WINDOW_MULTIPLIER_ASSERT_SVH
`define FRAME_WINDOW_MULTIPLIER_ASSERT_SVH
`ifndef SYNTHESIS
`define FWM_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("frame_window_multiplier: assertion failed");
`define FWM_NEVER(name, cond) `FWM_ASSERT(name, !(cond))
`else
`define FWM_ASSERT(name, prop)
`define FWM_NEVER(name, cond)
`endif
`endif

// ----- src/fwm_pkg.sv -----
// ---------------------------------------------------------------------------
// fwm_pkg
// Shared constants, types and table functions of the frame window multiplier.
// ---------------------------------------------------------------------------
package fwm_pkg;

   localparam int MAX_FRAME_DEF     = 4096;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int TABLE_ENTRIES_DEF = 1024;

   localparam int RESET_FRAME    = 1024;
   localparam int LEN_FIELD_BITS = 13;
   localparam int PHASE_BITS     = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 4;   // power of two
   localparam int DIV_STEPS      = 33;  // quotient of 2^32 needs 33 bits
   localparam int DIV_CNT_BITS   = 6;

   localparam logic [16:0] Q16_ONE     = 17'd65536;
   localparam logic [15:0] HAMMING_A   = 16'd35389;
   localparam logic [14:0] HAMMING_B   = 15'd30147;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   localparam logic [1:0] WIN_RECT    = 2'd0;
   localparam logic [1:0] WIN_HANN    = 2'd1;
   localparam logic [1:0] WIN_HAMMING = 2'd2;
   localparam logic [1:0] WIN_SINE    = 2'd3;

   localparam logic REG_WINDOW_TYPE  = 1'b0;
   localparam logic REG_FRAME_LENGTH = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } fwm_div_status_type;

   // queue entry: {window type, negative, table index, last, position, sample}
   function automatic int entry_bits(input int sample_bits, input int pos_bits,
                                     input int idx_bits);
      return sample_bits + pos_bits + idx_bits + 4;
   endfunction

   // sin(x) for x in Q2.30 (0..pi/2), rounded to Q1.16, saturated at one.
   // Elaboration-time only.
   function automatic logic [16:0] q16_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1: term = term / 6;
            2: term = term / 20;
            3: term = term / 42;
            4: term = term / 72;
            5: term = term / 110;
            default: term = term / 156;
         endcase
         if (n[0]) sum = sum - term;
         else      sum = sum + term;
      end
      v = (sum * 64'd65536 + (64'd1 << 29)) >> 30;
      return (v > 64'd65536) ? Q16_ONE : v[16:0];
   endfunction

endpackage

// ----- src/fwm_div.sv -----
// ---------------------------------------------------------------------------
// fwm_div
// Restoring divider, one quotient bit per cycle: 2^32 / divisor, kept to
// 32 bits, for the phase step.
// ---------------------------------------------------------------------------
`include "frame_window_multiplier_assert.svh"

module fwm_div import fwm_pkg::*; #(
   parameter int MAX_FRAME = MAX_FRAME_DEF,
   localparam int LEN_BITS = $clog2(MAX_FRAME + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [LEN_BITS-1:0]   divisor,
   output logic [PHASE_BITS-1:0] quotient,
   output fwm_div_status_type    status
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [LEN_BITS-1:0]     rem_ff, rem_in;
   logic [LEN_BITS-1:0]     div_ff, div_in;
   logic [PHASE_BITS-1:0]   quo_ff, quo_in;
   logic [LEN_BITS:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      // dividend is 2^32: a single one at the first step, zeros after
      trial   = {rem_ff, (cnt_ff == DIV_CNT_BITS'(DIV_STEPS))};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(DIV_STEPS);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = LEN_BITS'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[PHASE_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_BITS-1:0];
            quo_in = {quo_ff[PHASE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `FWM_ASSERT(div_done_ends_run, done_ff |-> $past(busy_ff) && !busy_ff)

endmodule

// ----- src/fwm_queue.sv -----
// ---------------------------------------------------------------------------
// fwm_queue
// Short register FIFO between the front and back parts.
// ---------------------------------------------------------------------------
`include "frame_window_multiplier_assert.svh"

module fwm_queue import fwm_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_BITS = $clog2(DEPTH),
   localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ff];
   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);

   `FWM_NEVER(queue_overflow, count_ff > CNT_BITS'(DEPTH))
   `FWM_NEVER(queue_push_full, push && full && !pop)
   `FWM_NEVER(queue_pop_empty, pop && empty)

endmodule

// ----- src/fwm_front.sv -----
// ---------------------------------------------------------------------------
// fwm_front
// Accepts samples, tracks frame position and phase, and classifies each
// item into a quarter-wave table index and sign for the back part.
// ---------------------------------------------------------------------------
module fwm_front import fwm_pkg::*; #(
   parameter int MAX_FRAME     = MAX_FRAME_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter logic [PHASE_BITS-1:0] RESET_INC = '0,
   localparam int LEN_BITS = $clog2(MAX_FRAME + 1),
   localparam int POS_BITS = $clog2(MAX_FRAME),
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES + 1),
   localparam int ENTRY_BITS = entry_bits(SAMPLE_BITS, POS_BITS, IDX_BITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   input  logic [1:0]             window_type,
   input  logic [LEN_BITS-1:0]    frame_length,
   input  logic                   restart,
   input  fwm_div_status_type     div_status,
   input  logic [PHASE_BITS-1:0]  div_quotient,
   input  logic                   queue_full,
   output logic                   push,
   output logic [ENTRY_BITS-1:0]  push_entry
);

   localparam int PROD_BITS = 30 + IDX_BITS;

   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] inc_ff, inc_in;
   logic [PHASE_BITS-1:0] angle;
   logic [PROD_BITS-1:0]  scaled;
   logic [IDX_BITS-1:0]   idx_near;
   logic [IDX_BITS-1:0]   idx;
   logic                  neg;
   logic                  last;

   assign in_ready = !div_status.busy && !div_status.done && !queue_full;
   assign push     = in_valid && in_ready;
   assign last     = (LEN_BITS'(pos_ff) >= frame_length - 1'b1);

   // cosine is sine a quarter turn ahead; the sine window spans half a turn
   always_comb begin
      case (window_type)
         WIN_HANN, WIN_HAMMING: angle = phase_ff + QUARTER_TURN;
         WIN_SINE:              angle = phase_ff >> 1;
         default:               angle = phase_ff;
      endcase
      scaled   = PROD_BITS'(angle[29:0]) * PROD_BITS'(TABLE_ENTRIES)
                 + PROD_BITS'(32'h2000_0000);
      idx_near = scaled[30 +: IDX_BITS];
      idx      = angle[30] ? IDX_BITS'(TABLE_ENTRIES) - idx_near : idx_near;
      neg      = angle[31];
   end

   assign push_entry = {window_type, neg, idx, last, pos_ff, in_sample};

   always_comb begin
      pos_in   = pos_ff;
      phase_in = phase_ff;
      inc_in   = div_status.done ? div_quotient : inc_ff;
      if (restart) begin
         pos_in   = '0;
         phase_in = '0;
      end else if (push) begin
         if (last) begin
            pos_in   = '0;
            phase_in = '0;
         end else begin
            pos_in   = pos_ff + 1'b1;
            phase_in = phase_ff + inc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= '0;
         inc_ff   <= RESET_INC;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         inc_ff   <= inc_in;
      end
   end

endmodule

// ----- src/fwm_back.sv -----
// ---------------------------------------------------------------------------
// fwm_back
// Table read, coefficient build, sample multiply and rounding, with an
// output register on the result channel.
// ---------------------------------------------------------------------------
module fwm_back import fwm_pkg::*; #(
   parameter int MAX_FRAME     = MAX_FRAME_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   localparam int POS_BITS = $clog2(MAX_FRAME),
   localparam int IDX_BITS = $clog2(TABLE_ENTRIES + 1),
   localparam int ENTRY_BITS = entry_bits(SAMPLE_BITS, POS_BITS, IDX_BITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   queue_empty,
   input  logic [ENTRY_BITS-1:0]  pop_entry,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_sample,
   output logic [POS_BITS-1:0]    out_pos,
   output logic                   out_last
);

   localparam int PROD_BITS = SAMPLE_BITS + 18;

   logic [16:0] sine_rom [TABLE_ENTRIES + 1];

   for (genvar k = 0; k <= TABLE_ENTRIES; k++) begin : g_rom
      localparam logic [63:0] XK = (HALF_PI_Q30 * 64'(k)) / 64'(TABLE_ENTRIES);
      assign sine_rom[k] = q16_sine(XK);
   end

   logic [1:0]             e_wt;
   logic                   e_neg;
   logic [IDX_BITS-1:0]    e_idx;
   logic                   e_last;
   logic [POS_BITS-1:0]    e_pos;
   logic [SAMPLE_BITS-1:0] e_sample;
   logic                   adv;

   assign {e_wt, e_neg, e_idx, e_last, e_pos, e_sample} = pop_entry;

   // whole pipeline moves together; the output register frees it
   assign adv = !out_valid || out_ready;
   assign pop = adv && !queue_empty;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff, vo_ff;
   logic [16:0]            m1_ff, m2_ff;
   logic [1:0]             wt1_ff, wt2_ff;
   logic                   neg1_ff, neg2_ff;
   logic [SAMPLE_BITS-1:0] s1_ff, s2_ff, s3_ff;
   logic [POS_BITS-1:0]    p1_ff, p2_ff, p3_ff, p4_ff, po_ff;
   logic                   l1_ff, l2_ff, l3_ff, l4_ff, lo_ff;
   logic [31:0]            ham2_ff;
   logic [16:0]            coef3_ff, coef3_in;
   logic signed [PROD_BITS-1:0] prod4_ff;
   logic [SAMPLE_BITS-1:0] yo_ff, yo_in;

   logic [32:0] ham_sum;
   logic [15:0] ham_p;
   logic [17:0] hann_t;

   always_comb begin
      ham_sum = {1'b0, ham2_ff} + 33'd32768;
      ham_p   = ham_sum[31:16];
      hann_t  = neg2_ff ? 18'(Q16_ONE) + 18'(m2_ff) + 18'd1
                        : 18'(Q16_ONE) - 18'(m2_ff) + 18'd1;
      case (wt2_ff)
         WIN_HANN:    coef3_in = hann_t[17:1];
         WIN_HAMMING: coef3_in = neg2_ff ? 17'(HAMMING_A) + 17'(ham_p)
                                         : 17'(HAMMING_A) - 17'(ham_p);
         WIN_SINE:    coef3_in = m2_ff;
         default:     coef3_in = Q16_ONE;
      endcase
   end

   logic signed [PROD_BITS-1:0] round_sum;

   always_comb begin
      round_sum = prod4_ff + PROD_BITS'(32768);
      yo_in     = round_sum[16 +: SAMPLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vo_ff <= v4_ff;
      end
      if (adv) begin
         m1_ff    <= sine_rom[e_idx];
         wt1_ff   <= e_wt;
         neg1_ff  <= e_neg;
         s1_ff    <= e_sample;
         p1_ff    <= e_pos;
         l1_ff    <= e_last;
         ham2_ff  <= 32'(HAMMING_B) * 32'(m1_ff);
         m2_ff    <= m1_ff;
         wt2_ff   <= wt1_ff;
         neg2_ff  <= neg1_ff;
         s2_ff    <= s1_ff;
         p2_ff    <= p1_ff;
         l2_ff    <= l1_ff;
         coef3_ff <= coef3_in;
         s3_ff    <= s2_ff;
         p3_ff    <= p2_ff;
         l3_ff    <= l2_ff;
         // both operands signed, widened to the full product by the target
         prod4_ff <= $signed(s3_ff) * $signed({1'b0, coef3_ff});
         p4_ff    <= p3_ff;
         l4_ff    <= l3_ff;
         yo_ff    <= yo_in;
         po_ff    <= p4_ff;
         lo_ff    <= l4_ff;
      end
   end

   assign out_valid  = vo_ff;
   assign out_sample = yo_ff;
   assign out_pos    = po_ff;
   assign out_last   = lo_ff;

endmodule

// ----- src/frame_window_multiplier.sv -----
// ---------------------------------------------------------------------------
// frame_window_multiplier
// Multiplies a sample stream by a rectangular, Hann, Hamming or sine window.
// ---------------------------------------------------------------------------
// Takes one signed Q1.15 sample per clock while req_tready is high and returns
// it scaled by the window coefficient for its place in the frame, rounded to
// nearest, with the position and a frame-end flag on tlast; one item per clock
// is sustained while rsp_tready is high and no divider run is pending. Items
// pass queue write, table read, Hamming scale, coefficient, multiply and
// rounding into the output register. Writing frame_length restarts the frame
// and runs a one-bit-per-cycle divider for the phase step; req_tready is low
// until the step is loaded. A window_type write applies from the next sample.
`include "frame_window_multiplier_assert.svh"

module frame_window_multiplier import fwm_pkg::*; #(
   parameter int MAX_FRAME     = MAX_FRAME_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   localparam int POS_BITS = $clog2(MAX_FRAME),
   localparam int REQ_BITS = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS = ((SAMPLE_BITS + POS_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_BITS-1:0]      req_tdata,   // sample
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_BITS-1:0]      rsp_tdata,   // windowed_sample, position
   output logic                     rsp_tlast,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int LEN_BITS   = $clog2(MAX_FRAME + 1);
   localparam int IDX_BITS   = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_BITS = entry_bits(SAMPLE_BITS, POS_BITS, IDX_BITS);
   localparam int RESET_LEN  = (RESET_FRAME > MAX_FRAME) ? MAX_FRAME : RESET_FRAME;
   localparam logic [63:0] RESET_INC_W = 64'h1_0000_0000 / 64'(RESET_LEN - 1);

   // configuration registers
   logic [1:0]          window_type_ff, window_type_in;
   logic [LEN_BITS-1:0] frame_length_ff, frame_length_in;
   logic                csr_write;
   logic                len_write;
   logic                csr_index;
   logic [31:0]         len_wide;
   logic [LEN_BITS-1:0] len_sat;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];
   assign len_write  = csr_write && (csr_index == REG_FRAME_LENGTH);

   always_comb begin
      len_wide = 32'(csr_pwdata[LEN_FIELD_BITS-1:0]);
      if (len_wide < 32'd2) len_wide = 32'd2;
      else if (len_wide > 32'(MAX_FRAME)) len_wide = 32'(MAX_FRAME);
      len_sat = LEN_BITS'(len_wide);

      window_type_in  = window_type_ff;
      frame_length_in = frame_length_ff;
      if (csr_write) begin
         case (csr_index)
            REG_WINDOW_TYPE:  window_type_in  = csr_pwdata[1:0];
            REG_FRAME_LENGTH: frame_length_in = len_sat;
            default: ;
         endcase
      end

      case (csr_index)
         REG_WINDOW_TYPE:  csr_prdata = CSR_DATA_BITS'(window_type_ff);
         REG_FRAME_LENGTH: csr_prdata = CSR_DATA_BITS'(frame_length_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_type_ff  <= WIN_RECT;
         frame_length_ff <= LEN_BITS'(RESET_LEN);
      end else begin
         window_type_ff  <= window_type_in;
         frame_length_ff <= frame_length_in;
      end
   end

   // phase step divider
   fwm_div_status_type    div_st;
   logic [PHASE_BITS-1:0] div_q;

   fwm_div #(
      .MAX_FRAME (MAX_FRAME)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (len_write),
      .divisor  (len_sat - 1'b1),
      .quotient (div_q),
      .status   (div_st)
   );

   logic                   push;
   logic [ENTRY_BITS-1:0]  push_entry;
   logic                   pop;
   logic [ENTRY_BITS-1:0]  pop_entry;
   logic                   q_full;
   logic                   q_empty;
   logic [SAMPLE_BITS-1:0] out_sample;
   logic [POS_BITS-1:0]    out_pos;

   fwm_front #(
      .MAX_FRAME     (MAX_FRAME),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .RESET_INC     (RESET_INC_W[PHASE_BITS-1:0])
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_sample    (req_tdata[SAMPLE_BITS-1:0]),
      .window_type  (window_type_ff),
      .frame_length (frame_length_ff),
      .restart      (len_write),
      .div_status   (div_st),
      .div_quotient (div_q),
      .queue_full   (q_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   fwm_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .full      (q_full),
      .empty     (q_empty)
   );

   fwm_back #(
      .MAX_FRAME     (MAX_FRAME),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_sample  (out_sample),
      .out_pos     (out_pos),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({out_pos, out_sample});

   `FWM_NEVER(no_accept_during_div, req_tvalid && req_tready && div_st.busy)
   `FWM_NEVER(no_accept_on_step_load, req_tvalid && req_tready && div_st.done)

endmodule
